@@ hdl/cqpm_pkg.sv @@
// Shared types, constants and width helpers for the convex quadrilateral mask.
// No dependencies; every other file imports this package.
package cqpm_pkg;

  // Fixed field widths
  localparam int VERT_W    = 17;
  localparam int LVL_W     = 3;
  localparam int CFG_IDX_W = 4;
  localparam int NUM_VERT  = 4;

  // Default parameter values
  localparam int DEF_LEVELS     = 8;
  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_FRAC_BITS  = 4;

  typedef logic signed [VERT_W-1:0] vert_t;
  typedef logic signed [VERT_W:0]   edge_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_V0_X = 4'd0,
    REG_V0_Y = 4'd1,
    REG_V1_X = 4'd2,
    REG_V1_Y = 4'd3,
    REG_V2_X = 4'd4,
    REG_V2_Y = 4'd5,
    REG_V3_X = 4'd6,
    REG_V3_Y = 4'd7
  } cfg_reg_t;

  // Vertices and the edge vectors between cyclic neighbours
  typedef struct packed {
    vert_t [NUM_VERT-1:0] vx;
    vert_t [NUM_VERT-1:0] vy;
    edge_t [NUM_VERT-1:0] dx;
    edge_t [NUM_VERT-1:0] dy;
  } quad_t;

  // Highest level that can take effect, limited by the level field width
  function automatic int max_level(int levels);
    int lim;
    lim = (1 << LVL_W) - 1;
    return (levels - 1 < lim) ? levels - 1 : lim;
  endfunction

  // Width of a scaled pixel coordinate
  function automatic int px_width(int coord_bits, int frac_bits, int levels);
    return coord_bits + frac_bits + max_level(levels);
  endfunction

  // Width of pixel minus vertex, signed
  function automatic int diff_width(int px_w);
    return ((px_w + 1 > VERT_W) ? px_w + 1 : VERT_W) + 1;
  endfunction

endpackage

@@ hdl/cqpm_cfg.sv @@
// Vertex register file and registered edge vectors.
// Depends on cqpm_pkg.
module cqpm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [cqpm_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [cqpm_pkg::VERT_W-1:0]      wr_data,
  output cqpm_pkg::quad_t                  quad
);
  import cqpm_pkg::*;

  vert_t vx_r [NUM_VERT];
  vert_t vy_r [NUM_VERT];
  edge_t dx_r [NUM_VERT];
  edge_t dy_r [NUM_VERT];

  // Write one vertex coordinate; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_VERT; k++) begin
        vx_r[k] <= '0;
        vy_r[k] <= '0;
      end
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_V0_X: vx_r[0] <= wr_data;
        REG_V0_Y: vy_r[0] <= wr_data;
        REG_V1_X: vx_r[1] <= wr_data;
        REG_V1_Y: vy_r[1] <= wr_data;
        REG_V2_X: vx_r[2] <= wr_data;
        REG_V2_Y: vy_r[2] <= wr_data;
        REG_V3_X: vx_r[3] <= wr_data;
        REG_V3_Y: vy_r[3] <= wr_data;
        default: ;
      endcase
    end
  end

  // Hold edge k as vertex k+1 minus vertex k, cyclically
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_VERT; k++) begin
        dx_r[k] <= '0;
        dy_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_VERT; k++) begin
        dx_r[k] <= edge_t'(vx_r[(k + 1) % NUM_VERT]) - edge_t'(vx_r[k]);
        dy_r[k] <= edge_t'(vy_r[(k + 1) % NUM_VERT]) - edge_t'(vy_r[k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_VERT; k++) begin
      quad.vx[k] = vx_r[k];
      quad.vy[k] = vy_r[k];
      quad.dx[k] = dx_r[k];
      quad.dy[k] = dy_r[k];
    end
  end

endmodule

@@ hdl/cqpm_scale.sv @@
// Stage one: saturate the level and scale the pixel up to level-0 fixed point.
// Depends on cqpm_pkg.
module cqpm_scale #(
  parameter int COORD_BITS = cqpm_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = cqpm_pkg::DEF_FRAC_BITS,
  parameter int LEVELS     = cqpm_pkg::DEF_LEVELS,
  parameter int PX_W       = cqpm_pkg::px_width(COORD_BITS, FRAC_BITS, LEVELS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic [COORD_BITS-1:0]        pixel_x,
  input  logic [COORD_BITS-1:0]        pixel_y,
  input  logic [cqpm_pkg::LVL_W-1:0]   level,
  output logic                         m_valid,
  input  logic                         m_ready,
  output logic [PX_W-1:0]              m_px,
  output logic [PX_W-1:0]              m_py
);
  import cqpm_pkg::*;

  localparam int MAX_LVL = max_level(LEVELS);
  localparam int SH_W    = $clog2(FRAC_BITS + MAX_LVL + 1) + 1;

  logic [LVL_W-1:0] lev;
  logic [SH_W-1:0]  sh;
  logic [PX_W-1:0]  px_nxt, py_nxt;
  logic [PX_W-1:0]  px_r, py_r;
  logic             valid_r;

  // Clamp the level and shift by level plus fraction bits
  always_comb begin
    lev    = (level > LVL_W'(MAX_LVL)) ? LVL_W'(MAX_LVL) : level;
    sh     = SH_W'(lev) + SH_W'(FRAC_BITS);
    px_nxt = PX_W'(pixel_x) << sh;
    py_nxt = PX_W'(pixel_y) << sh;
  end

  assign s_ready = !valid_r || m_ready;

  // Advance the valid bit whenever the stage may move
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_px    = px_r;
  assign m_py    = py_r;

endmodule

@@ hdl/cqpm_edge.sv @@
// Stages two and three: pixel-to-vertex offsets, then the two cross products per edge.
// Depends on cqpm_pkg.
module cqpm_edge #(
  parameter int PX_W   = cqpm_pkg::px_width(cqpm_pkg::DEF_COORD_BITS,
                                            cqpm_pkg::DEF_FRAC_BITS,
                                            cqpm_pkg::DEF_LEVELS),
  parameter int PROD_W = cqpm_pkg::diff_width(PX_W) + cqpm_pkg::VERT_W + 1
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  cqpm_pkg::quad_t                              quad,
  input  logic                                         s_valid,
  output logic                                         s_ready,
  input  logic [PX_W-1:0]                              s_px,
  input  logic [PX_W-1:0]                              s_py,
  output logic                                         m_valid,
  input  logic                                         m_ready,
  output logic [cqpm_pkg::NUM_VERT-1:0][PROD_W-1:0]    m_lhs,
  output logic [cqpm_pkg::NUM_VERT-1:0][PROD_W-1:0]    m_rhs
);
  import cqpm_pkg::*;

  localparam int DW = diff_width(PX_W);

  logic signed [DW-1:0]     dpx_nxt [NUM_VERT];
  logic signed [DW-1:0]     dpy_nxt [NUM_VERT];
  logic signed [DW-1:0]     dpx_r   [NUM_VERT];
  logic signed [DW-1:0]     dpy_r   [NUM_VERT];
  logic signed [PROD_W-1:0] lhs_nxt [NUM_VERT];
  logic signed [PROD_W-1:0] rhs_nxt [NUM_VERT];
  logic signed [PROD_W-1:0] lhs_r   [NUM_VERT];
  logic signed [PROD_W-1:0] rhs_r   [NUM_VERT];
  logic                     v2_r, v3_r;
  logic                     rdy2, rdy3;

  assign rdy3    = !v3_r || m_ready;
  assign rdy2    = !v2_r || rdy3;
  assign s_ready = rdy2;

  // Offset of the scaled pixel from each vertex
  always_comb begin
    for (int k = 0; k < NUM_VERT; k++) begin
      dpx_nxt[k] = $signed({{(DW - PX_W){1'b0}}, s_px}) - DW'($signed(quad.vx[k]));
      dpy_nxt[k] = $signed({{(DW - PX_W){1'b0}}, s_py}) - DW'($signed(quad.vy[k]));
    end
  end

  // Edge vector crossed with the offset, one product pair per edge
  always_comb begin
    for (int k = 0; k < NUM_VERT; k++) begin
      lhs_nxt[k] = $signed(quad.dx[k]) * dpy_r[k];
      rhs_nxt[k] = dpx_r[k] * $signed(quad.dy[k]);
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= s_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s_valid) begin
      for (int k = 0; k < NUM_VERT; k++) begin
        dpx_r[k] <= dpx_nxt[k];
        dpy_r[k] <= dpy_nxt[k];
      end
    end
    if (rdy3 && v2_r) begin
      for (int k = 0; k < NUM_VERT; k++) begin
        lhs_r[k] <= lhs_nxt[k];
        rhs_r[k] <= rhs_nxt[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_VERT; k++) begin
      m_lhs[k] = lhs_r[k];
      m_rhs[k] = rhs_r[k];
    end
  end

  assign m_valid = v3_r;

endmodule

@@ hdl/cqpm_decide.sv @@
// Stage four: sign of each edge test, combined into the inside flag (output register).
// Depends on cqpm_pkg.
module cqpm_decide #(
  parameter int PROD_W = cqpm_pkg::diff_width(cqpm_pkg::px_width(
                           cqpm_pkg::DEF_COORD_BITS, cqpm_pkg::DEF_FRAC_BITS,
                           cqpm_pkg::DEF_LEVELS)) + cqpm_pkg::VERT_W + 1
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       s_valid,
  output logic                                       s_ready,
  input  logic [cqpm_pkg::NUM_VERT-1:0][PROD_W-1:0]  s_lhs,
  input  logic [cqpm_pkg::NUM_VERT-1:0][PROD_W-1:0]  s_rhs,
  output logic                                       m_valid,
  input  logic                                       m_ready,
  output logic                                       m_inside
);
  import cqpm_pkg::*;

  logic signed [PROD_W:0] diff [NUM_VERT];
  logic [NUM_VERT-1:0]    ok;
  logic                   inside_nxt;
  logic                   inside_r;
  logic                   valid_r;

  // An edge passes when lhs - rhs is not negative
  always_comb begin
    for (int k = 0; k < NUM_VERT; k++) begin
      diff[k] = $signed({s_lhs[k][PROD_W-1], s_lhs[k]})
              - $signed({s_rhs[k][PROD_W-1], s_rhs[k]});
      ok[k]   = !diff[k][PROD_W];
    end
    inside_nxt = &ok;
  end

  assign s_ready = !valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      inside_r <= inside_nxt;
    end
  end

  assign m_valid  = valid_r;
  assign m_inside = inside_r;

endmodule

@@ hdl/convex_quad_pyramid_mask_core.sv @@
// Throughput: one pixel per clock while out_ready is high; four register stages (scale, offset,
// multiply, sign test) each hold one transaction and advance when empty or when the next one moves.
// Reset (synchronous, rst_n low) empties every stage and sets all vertices to zero.
// Depends on cqpm_pkg, cqpm_cfg, cqpm_scale, cqpm_edge and cqpm_decide.
module convex_quad_pyramid_mask_core #(
  parameter int LEVELS     = cqpm_pkg::DEF_LEVELS,
  parameter int COORD_BITS = cqpm_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = cqpm_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [COORD_BITS-1:0]            in_pixel_x,
  input  logic [COORD_BITS-1:0]            in_pixel_y,
  input  logic [cqpm_pkg::LVL_W-1:0]       in_pyramid_level,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_inside_res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cqpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cqpm_pkg::VERT_W-1:0]      cfg_wdata
);
  import cqpm_pkg::*;

  localparam int PX_W   = px_width(COORD_BITS, FRAC_BITS, LEVELS);
  localparam int PROD_W = diff_width(PX_W) + VERT_W + 1;

  quad_t                            quad;
  logic                             sc_valid, sc_ready;
  logic [PX_W-1:0]                  sc_px, sc_py;
  logic                             ed_valid, ed_ready;
  logic [NUM_VERT-1:0][PROD_W-1:0]  ed_lhs, ed_rhs;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  cqpm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .quad     (quad)
  );

  cqpm_scale #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .LEVELS     (LEVELS),
    .PX_W       (PX_W)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_valid),
    .s_ready (in_ready),
    .pixel_x (in_pixel_x),
    .pixel_y (in_pixel_y),
    .level   (in_pyramid_level),
    .m_valid (sc_valid),
    .m_ready (sc_ready),
    .m_px    (sc_px),
    .m_py    (sc_py)
  );

  cqpm_edge #(
    .PX_W   (PX_W),
    .PROD_W (PROD_W)
  ) u_edge (
    .clk     (clk),
    .rst_n   (rst_n),
    .quad    (quad),
    .s_valid (sc_valid),
    .s_ready (sc_ready),
    .s_px    (sc_px),
    .s_py    (sc_py),
    .m_valid (ed_valid),
    .m_ready (ed_ready),
    .m_lhs   (ed_lhs),
    .m_rhs   (ed_rhs)
  );

  cqpm_decide #(
    .PROD_W (PROD_W)
  ) u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (ed_valid),
    .s_ready  (ed_ready),
    .s_lhs    (ed_lhs),
    .s_rhs    (ed_rhs),
    .m_valid  (out_valid),
    .m_ready  (out_ready),
    .m_inside (out_inside_res)
  );

`ifndef SYNTHESIS
  // The input only stalls when the whole pipeline is full and the output is held
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while pipeline could advance");

  // A write to an index beyond the vertex list leaves every vertex alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index > CFG_IDX_W'(REG_V3_Y)))
      |=> ($stable(quad.vx) && $stable(quad.vy)))
    else $error("out-of-range register write changed a vertex");

  // Edge vectors follow the vertices once they have settled
  assert property (@(posedge clk) disable iff (!rst_n)
    ($stable(quad.vx) && $stable(quad.vy))
      |=> (quad.dx[0] == edge_t'($past(quad.vx[1])) - edge_t'($past(quad.vx[0]))))
    else $error("edge vector out of step with vertices");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for convex_quad_pyramid_mask_core: it predicts the inside flag
// of every pixel from the four cyclic edge tests and compares each result in order.
// Depends on cqpm_pkg and the core; no files, arguments or seeds are read.
module tb;
  import cqpm_pkg::*;

  localparam int COORD_W      = DEF_COORD_BITS;
  localparam int MAX_LEVEL    = DEF_LEVELS - 1;
  localparam int PIPE_LATENCY = 4;
  localparam int MAX_GAP      = 18;
  localparam int HOLD_OFF     = 80;
  localparam int QUIET_LIMIT  = 1000;
  localparam int VERT_MIN     = -(1 << (VERT_W - 1));
  localparam int VERT_MAX     = (1 << (VERT_W - 1)) - 1;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;
  localparam int QREG_IDX_W   = $clog2(2 * NUM_VERT);
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_IDX = CFG_IDX_W'(REG_V3_Y + 1);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COORD_W-1:0]   in_pixel_x = '0;
  logic [COORD_W-1:0]   in_pixel_y = '0;
  logic [LVL_W-1:0]     in_pyramid_level = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_inside_res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VERT_W-1:0]    cfg_wdata = '0;

  // Predictor copy of the vertex registers and the flags still owed by the core
  vert_t quad_reg [2*NUM_VERT] = '{default: '0};
  bit    pending_inside [$];
  int    fail_count = 0;
  int    quiet_cycles = 0;
  bit    in_idle_en = 1'b1;
  bit    out_idle_en = 1'b1;
  int    hold_cycles = 0;
  int    quad_x [NUM_VERT];
  int    quad_y [NUM_VERT];

  convex_quad_pyramid_mask_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .in_pyramid_level (in_pyramid_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_inside_res   (out_inside_res),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scale the pixel up to level-0 fixed point and apply the test of every edge
  function automatic bit inside_of_quad(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                        logic [LVL_W-1:0] level);
    int     shift;
    int     k;
    int     k1;
    longint px, py, xa, ya, xb, yb;
    bit     in_quad;
    shift = (int'(level) > MAX_LEVEL) ? MAX_LEVEL : int'(level);
    shift = shift + DEF_FRAC_BITS;
    px = longint'(x) << shift;
    py = longint'(y) << shift;
    in_quad = 1'b1;
    for (k = 0; k < NUM_VERT; k++) begin
      k1 = (k + 1) % NUM_VERT;
      xa = quad_reg[2*k];
      ya = quad_reg[2*k+1];
      xb = quad_reg[2*k1];
      yb = quad_reg[2*k1+1];
      // a product of exactly zero lies on the edge and counts as inside
      if ((xb - xa) * (py - ya) - (px - xa) * (yb - ya) < 0) in_quad = 1'b0;
    end
    return in_quad;
  endfunction

  function automatic int clamp_vert(int v);
    return (v < VERT_MIN) ? VERT_MIN : (v > VERT_MAX) ? VERT_MAX : v;
  endfunction

  // Check results against the oldest prediction, then record new transactions
  always @(posedge clk) begin : scoreboard
    bit want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_inside.size() == 0) begin
          $error("inside_res: result with nothing pending, actual %0d", out_inside_res);
          fail_count++;
        end else begin
          want = pending_inside.pop_front();
          if (out_inside_res !== want) begin
            $error("inside_res mismatch: expected %0d, actual %0d", want, out_inside_res);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_inside.push_back(inside_of_quad(in_pixel_x, in_pixel_y, in_pyramid_level));
      if (cfg_valid && cfg_ready && cfg_index < FIRST_SPARE_IDX)
        quad_reg[cfg_index[QREG_IDX_W-1:0]] = cfg_wdata;
    end
  end

  // Count cycles in which no channel moves a transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: stall at random before each transaction, or hold off on request
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_cycles != 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = out_idle_en ? int'($urandom_range(0, MAX_GAP)) : 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Offer one pixel after a random gap; valid stays high for a back-to-back follower
  task automatic send_pixel(input int x, input int y, input int level);
    int gap;
    gap = in_idle_en ? int'($urandom_range(0, MAX_GAP)) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pixel_x       <= COORD_W'(x);
    in_pixel_y       <= COORD_W'(y);
    in_pyramid_level <= LVL_W'(level);
    in_valid         <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  // Mostly pixels within the level's share of the vertex range, some anywhere
  task automatic send_random_pixel;
    int level;
    int span;
    level = int'($urandom_range(0, MAX_LEVEL));
    span = ($urandom_range(0, 3) == 0) ? COORD_MAX : (COORD_MAX >> level);
    send_pixel(int'($urandom_range(0, span)), int'($urandom_range(0, span)), level);
  endtask

  // Drop valid and wait until every predicted flag has come back
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_inside.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_index <= idx;
    cfg_wdata <= VERT_W'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
  endtask

  // Write the staged vertices once the core is idle
  task automatic load_quad;
    drain();
    cfg_write(REG_V0_X, quad_x[0]);
    cfg_write(REG_V0_Y, quad_y[0]);
    cfg_write(REG_V1_X, quad_x[1]);
    cfg_write(REG_V1_Y, quad_y[1]);
    cfg_write(REG_V2_X, quad_x[2]);
    cfg_write(REG_V2_Y, quad_y[2]);
    cfg_write(REG_V3_X, quad_x[3]);
    cfg_write(REG_V3_Y, quad_y[3]);
    cfg_valid <= 1'b0;
  endtask

  // Convex kites in either winding, or arbitrary vertices, at a random start vertex
  task automatic load_random_quad;
    int kind, cx, cy, ax, bx, ay, by, jit, spin, k, idx;
    int tx [NUM_VERT];
    int ty [NUM_VERT];
    kind = int'($urandom_range(0, 9));
    cx = int'($urandom_range(0, 70000)) - 4000;
    cy = int'($urandom_range(0, 70000)) - 4000;
    ax = int'($urandom_range(16, 24000));
    bx = int'($urandom_range(16, 24000));
    ay = int'($urandom_range(16, 24000));
    by = int'($urandom_range(16, 24000));
    jit = ((ax < bx) ? ax : bx) / 2;
    tx[0] = cx + int'($urandom_range(0, 2 * jit)) - jit;
    ty[0] = cy - ay;
    tx[1] = cx + ax;
    ty[1] = cy;
    tx[2] = cx + int'($urandom_range(0, 2 * jit)) - jit;
    ty[2] = cy + by;
    tx[3] = cx - bx;
    ty[3] = cy;
    if (kind >= 8) begin
      for (k = 0; k < NUM_VERT; k++) begin
        tx[k] = int'($urandom_range(0, VERT_MAX - VERT_MIN)) + VERT_MIN;
        ty[k] = int'($urandom_range(0, VERT_MAX - VERT_MIN)) + VERT_MIN;
      end
    end
    spin = int'($urandom_range(0, NUM_VERT - 1));
    for (k = 0; k < NUM_VERT; k++) begin
      idx = (kind == 6 || kind == 7) ? (spin + NUM_VERT - k) % NUM_VERT
                                     : (spin + k) % NUM_VERT;
      quad_x[k] = clamp_vert(tx[idx]);
      quad_y[k] = clamp_vert(ty[idx]);
    end
    load_quad();
  endtask

  task automatic stage_square(input int lo, input int hi, input bit clockwise);
    quad_x[0] = lo;
    quad_y[0] = lo;
    quad_x[2] = hi;
    quad_y[2] = hi;
    quad_x[1] = clockwise ? lo : hi;
    quad_y[1] = clockwise ? hi : lo;
    quad_x[3] = clockwise ? hi : lo;
    quad_y[3] = clockwise ? lo : hi;
  endtask

  // All vertices coincide after reset, so every pixel is inside
  task automatic test_reset_quad;
    send_pixel(0, 0, 0);
    send_pixel(COORD_MAX, COORD_MAX, MAX_LEVEL);
    send_pixel(COORD_MAX, 0, 0);
    send_pixel(0, COORD_MAX, MAX_LEVEL);
    send_pixel(2730, 1365, 2);
  endtask

  // Square over level-0 pixels 100 to 200: edges, corners and scaled levels
  task automatic test_edge_cases;
    stage_square(1600, 3200, 1'b0);
    load_quad();
    send_pixel(100, 150, 0);
    send_pixel(99, 150, 0);
    send_pixel(200, 200, 0);
    send_pixel(201, 150, 0);
    send_pixel(50, 75, 1);
    send_pixel(25, 25, 2);
    send_pixel(24, 30, 2);
    send_pixel(150, 150, 0);
    send_pixel(1, 1, MAX_LEVEL);
  endtask

  // Writes beyond the last register index must leave the square untouched
  task automatic test_spare_index;
    int i;
    drain();
    for (i = int'(FIRST_SPARE_IDX); i < (1 << CFG_IDX_W); i++)
      cfg_write(CFG_IDX_W'(i), int'($urandom_range(0, VERT_MAX - VERT_MIN)) + VERT_MIN);
    cfg_valid <= 1'b0;
    send_pixel(99, 150, 0);
    send_pixel(150, 150, 0);
  endtask

  // Full-range square in both windings
  task automatic test_extreme_quad;
    stage_square(VERT_MIN, VERT_MAX, 1'b0);
    load_quad();
    send_pixel(COORD_MAX, COORD_MAX, 0);
    send_pixel(COORD_MAX, COORD_MAX, MAX_LEVEL);
    send_pixel(16, 16, MAX_LEVEL);
    stage_square(VERT_MIN, VERT_MAX, 1'b1);
    load_quad();
    send_pixel(0, 0, 0);
    send_pixel(2048, 2048, 0);
  endtask

  // Random quads, each with a burst of pixels under a random idling mode
  task automatic test_random_quads;
    int phase;
    int n;
    int mode;
    for (phase = 0; phase < 12; phase++) begin
      load_random_quad();
      mode = int'($urandom_range(0, 3));
      in_idle_en  = (mode == 0 || mode == 1);
      out_idle_en = (mode == 0 || mode == 2);
      for (n = 0; n < 35; n++) send_random_pixel();
    end
  endtask

  // Hold the result side off while pixels keep coming, then pause the sender
  task automatic test_backpressure;
    int n;
    in_idle_en  = 1'b0;
    out_idle_en = 1'b1;
    load_random_quad();
    hold_cycles = HOLD_OFF;
    for (n = 0; n < 12; n++) send_random_pixel();
    drain();
    for (n = 0; n < 12; n++) send_random_pixel();
    in_idle_en = 1'b1;
  endtask

  initial begin : run
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_quad();
    test_edge_cases();
    test_spare_index();
    test_extreme_quad();
    test_random_quads();
    test_backpressure();
    drain();
    repeat (PIPE_LATENCY * 4) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/cqpm_pkg.sv
hdl/cqpm_cfg.sv
hdl/cqpm_scale.sv
hdl/cqpm_edge.sv
hdl/cqpm_decide.sv
hdl/convex_quad_pyramid_mask_core.sv
tb/tb.sv
